[sv/arll_pkg.sv]
package arll_pkg;

    localparam int TYPE_W = 2;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam int STS_W  = 2;
    localparam int CFG_W  = 32;

    // request kinds
    localparam logic [TYPE_W-1:0] REQ_INS_AFTER  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_INS_BEFORE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE     = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_READ       = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD  = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [IDX_W-1:0]  anchor_index;
        logic [DATA_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] value_out;
        logic [IDX_W-1:0]  next_slot;
        logic [IDX_W-1:0]  prev_slot;
        logic [IDX_W-1:0]  element_count;
    } t_res;

endpackage

[sv/arll_req_if.sv]
interface arll_req_if;
    logic            valid;
    logic            ready;
    arll_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/arll_res_if.sv]
interface arll_res_if;
    logic            valid;
    logic            ready;
    arll_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/arll_cfg_if.sv]
interface arll_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [arll_pkg::CFG_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/arll_ram.sv]
module arll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/array_linked_list_engine.sv]
// Channel   Dir  Payload                                               Moves on
// i_req     in   req_type, anchor_index, item_value                    valid & ready
// o_res     out  status, slot, value_out, next_slot, prev_slot, count  valid & ready
// i_cfg     in   poison word                                           valid & ready
//
// Read requests and rejected requests pass from accept through the anchor check and the
// result state back to idle; inserts and removes also pass through the write states ST_I1
// and ST_I2 or ST_R1 and ST_R2, as each link memory has a single write port. After reset
// a clearing pass over every slot rebuilds the free chain in the link memories; no item is
// taken meanwhile, configuration writes are. The result register holds an item until taken;
// the sequencer waits in its last state while that register is full and not being drained.
module array_linked_list_engine #(
    parameter int SLOT_COUNT  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    arll_req_if.sink          i_req,
    arll_res_if.source        o_res,
    arll_cfg_if.sink          i_cfg
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_A    = 3'd2;
    localparam logic [2:0] ST_I1   = 3'd3;
    localparam logic [2:0] ST_I2   = 3'd4;
    localparam logic [2:0] ST_R1   = 3'd5;
    localparam logic [2:0] ST_R2   = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    // control state
    logic [2:0]                    r_state, n_state;
    logic [SW-1:0]                 r_clr, n_clr;
    logic [SW-1:0]                 r_free_top, n_free_top;
    logic [SW-1:0]                 r_count, n_count;
    logic                          r_ov, n_ov;
    logic [VW-1:0]                 r_poison, n_poison;

    // per-item payload
    logic [arll_pkg::TYPE_W-1:0]   r_kind, n_kind;
    logic [arll_pkg::IDX_W-1:0]    r_anchor, n_anchor;
    logic [VW-1:0]                 r_ival, n_ival;
    logic [SW-1:0]                 r_base, n_base;
    logic [SW-1:0]                 r_after, n_after;
    logic [SW-1:0]                 r_s, n_s;
    arll_pkg::t_res                r_res, n_res;
    arll_pkg::t_res                r_out, n_out;

    // memory ports
    logic [SW-1:0]  w_rd_addr, w_nx_raddr;
    logic [SW-1:0]  w_nx_rd, w_pv_rd;
    logic           w_us_rd;
    logic [VW-1:0]  w_vl_rd;
    logic           w_nx_we, w_pv_we, w_us_we, w_vl_we;
    logic [SW-1:0]  w_nx_wa, w_pv_wa, w_us_wa, w_vl_wa;
    logic [SW-1:0]  w_nx_wd, w_pv_wd;
    logic           w_us_wd;
    logic [VW-1:0]  w_vl_wd;

    logic [SW-1:0]  w_a_slot;
    logic           w_in_range;
    logic           w_ok;

    assign w_a_slot   = SW'(r_anchor);
    assign w_in_range = 32'(r_anchor) < 32'(SLOT_COUNT);
    assign w_ok       = w_in_range && ((r_anchor == '0) || w_us_rd);

    assign w_rd_addr  = (r_state == ST_IDLE) ? SW'(i_req.data.anchor_index) : w_a_slot;
    // fetch the free stack's successor while the anchor is checked
    assign w_nx_raddr = (r_state == ST_A) ? r_free_top : w_rd_addr;

    arll_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nx_we),
        .i_waddr (w_nx_wa),
        .i_wdata (w_nx_wd),
        .i_raddr (w_nx_raddr),
        .o_rdata (w_nx_rd)
    );

    arll_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_pv_we),
        .i_waddr (w_pv_wa),
        .i_wdata (w_pv_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_pv_rd)
    );

    arll_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_us_we),
        .i_waddr (w_us_wa),
        .i_wdata (w_us_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_us_rd)
    );

    arll_ram #(.WIDTH(VW), .DEPTH(SLOT_COUNT)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_vl_we),
        .i_waddr (w_vl_wa),
        .i_wdata (w_vl_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_vl_rd)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_free_top = r_free_top;
        n_count    = r_count;
        n_ov       = r_ov;
        n_poison   = r_poison;
        n_kind     = r_kind;
        n_anchor   = r_anchor;
        n_ival     = r_ival;
        n_base     = r_base;
        n_after    = r_after;
        n_s        = r_s;
        n_res      = r_res;
        n_out      = r_out;

        w_nx_we = 1'b0;  w_nx_wa = w_a_slot;  w_nx_wd = '0;
        w_pv_we = 1'b0;  w_pv_wa = w_a_slot;  w_pv_wd = '0;
        w_us_we = 1'b0;  w_us_wa = w_a_slot;  w_us_wd = 1'b0;
        w_vl_we = 1'b0;  w_vl_wa = w_a_slot;  w_vl_wd = r_poison;

        if (i_cfg.valid) begin
            n_poison = VW'(i_cfg.data);
        end

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                // chain every slot but the sentinel into the free stack
                w_nx_we = 1'b1;
                w_nx_wa = r_clr;
                w_nx_wd = ((r_clr == '0) || (r_clr == SW'(SLOT_COUNT - 1))) ?
                          '0 : SW'(r_clr + 1'b1);
                w_pv_we = 1'b1;
                w_pv_wa = r_clr;
                w_us_we = 1'b1;
                w_us_wa = r_clr;
                n_clr   = SW'(r_clr + 1'b1);
                if (r_clr == SW'(SLOT_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = i_req.data.req_type;
                    n_anchor = i_req.data.anchor_index;
                    n_ival   = VW'(i_req.data.item_value);
                    n_state  = ST_A;
                end
            end
            ST_A: begin
                n_res.status        = arll_pkg::STS_BAD;
                n_res.slot          = r_anchor;
                n_res.value_out     = '0;
                n_res.next_slot     = '0;
                n_res.prev_slot     = '0;
                n_res.element_count = '0;
                n_state             = ST_DONE;
                // before an anchor means after its predecessor, ahead of the anchor
                n_base  = (r_kind == arll_pkg::REQ_INS_AFTER) ? w_a_slot : w_pv_rd;
                n_after = (r_kind == arll_pkg::REQ_INS_BEFORE) ? w_a_slot : w_nx_rd;
                n_s     = r_free_top;
                case (r_kind)
                    arll_pkg::REQ_INS_AFTER, arll_pkg::REQ_INS_BEFORE: begin
                        if (w_ok) begin
                            if (r_free_top == '0) begin
                                n_res.status = arll_pkg::STS_FULL;
                            end else begin
                                n_state = ST_I1;
                            end
                        end
                    end
                    arll_pkg::REQ_REMOVE: begin
                        if (w_ok && (r_anchor != '0)) begin
                            n_res.value_out = 32'(w_vl_rd);
                            n_state         = ST_R1;
                        end
                    end
                    default: begin
                        if (w_ok) begin
                            n_res.status    = arll_pkg::STS_OK;
                            n_res.value_out = (r_anchor == '0) ? '0 : 32'(w_vl_rd);
                            n_res.next_slot = 8'(w_nx_rd);
                            n_res.prev_slot = 8'(w_pv_rd);
                        end
                    end
                endcase
            end
            ST_I1: begin
                n_free_top = w_nx_rd;
                w_nx_we = 1'b1;  w_nx_wa = r_base;   w_nx_wd = r_s;
                w_pv_we = 1'b1;  w_pv_wa = r_after;  w_pv_wd = r_s;
                w_us_we = 1'b1;  w_us_wa = r_s;      w_us_wd = 1'b1;
                w_vl_we = 1'b1;  w_vl_wa = r_s;      w_vl_wd = r_ival;
                n_count = SW'(r_count + 1'b1);
                n_state = ST_I2;
            end
            ST_I2: begin
                w_nx_we = 1'b1;  w_nx_wa = r_s;  w_nx_wd = r_after;
                w_pv_we = 1'b1;  w_pv_wa = r_s;  w_pv_wd = r_base;
                n_res.status    = arll_pkg::STS_OK;
                n_res.slot      = 8'(r_s);
                n_res.value_out = '0;
                n_res.next_slot = 8'(r_after);
                n_res.prev_slot = 8'(r_base);
                n_state         = ST_DONE;
            end
            ST_R1: begin
                // unlink: predecessor and successor point at each other
                w_nx_we = 1'b1;  w_nx_wa = r_base;   w_nx_wd = r_after;
                w_pv_we = 1'b1;  w_pv_wa = r_after;  w_pv_wd = r_base;
                w_vl_we = 1'b1;  w_vl_wa = w_a_slot; w_vl_wd = r_poison;
                w_us_we = 1'b1;  w_us_wa = w_a_slot; w_us_wd = 1'b0;
                n_state = ST_R2;
            end
            ST_R2: begin
                // push the freed slot onto the free stack
                w_nx_we = 1'b1;  w_nx_wa = w_a_slot;  w_nx_wd = r_free_top;
                w_pv_we = 1'b1;  w_pv_wa = w_a_slot;  w_pv_wd = '0;
                n_res.status    = arll_pkg::STS_OK;
                n_res.slot      = r_anchor;
                n_res.next_slot = 8'(r_free_top);
                n_res.prev_slot = '0;
                n_free_top      = w_a_slot;
                n_count         = SW'(r_count - 1'b1);
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_out               = r_res;
                    n_out.element_count = 8'(r_count);
                    n_ov                = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr      <= '0;
            r_free_top <= SW'(1);
            r_count    <= '0;
            r_ov       <= 1'b0;
            r_poison   <= '0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_free_top <= n_free_top;
            r_count    <= n_count;
            r_ov       <= n_ov;
            r_poison   <= n_poison;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_anchor <= n_anchor;
        r_ival   <= n_ival;
        r_base   <= n_base;
        r_after  <= n_after;
        r_s      <= n_s;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_I1) |=> (r_count == SW'($past(r_count) + 1'b1)))
        else $error("insert did not advance the element count");

    a_insert_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_I1) |-> (r_s != '0))
        else $error("insert took the sentinel slot");

    a_remove_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R1) |-> ((r_anchor != '0) && (r_kind == arll_pkg::REQ_REMOVE)))
        else $error("remove sequence entered for sentinel or wrong request");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ov && !o_res.ready) |=>
        (r_state == ST_DONE && $stable(r_out)))
        else $error("result overwritten while the output item is stalled");

endmodule

[tb/tb.sv]
module tb;

    localparam int SLOTS          = 256;
    localparam int IDLE_PCT       = 35;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_AT       = 300;
    localparam int STALL_CYCLES   = 400;

    logic i_clk;
    logic i_rst_n;

    arll_req_if req_ch ();
    arll_res_if res_ch ();
    arll_cfg_if cfg_ch ();

    array_linked_list_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // list image kept by the testbench
    logic [arll_pkg::DATA_W-1:0] slot_value [SLOTS];
    logic [arll_pkg::IDX_W-1:0]  link_next  [SLOTS];
    logic [arll_pkg::IDX_W-1:0]  link_prev  [SLOTS];
    bit                          slot_live  [SLOTS];
    logic [arll_pkg::IDX_W-1:0]  free_head;
    logic [arll_pkg::IDX_W-1:0]  live_total;
    logic [arll_pkg::CFG_W-1:0]  poison_word;

    arll_pkg::t_req pending [$];
    arll_pkg::t_res results_due [$];

    bit steady = 1'b0;
    int errors = 0;
    int n_taken = 0;
    int n_ok = 0;
    int n_full = 0;
    int n_bad = 0;
    int n_poison = 0;
    int peak_live = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_list();
        for (int i = 0; i < SLOTS; i++) begin
            slot_value[i] = '0;
            link_next[i]  = (i == 0 || i == SLOTS - 1) ? '0 : arll_pkg::IDX_W'(i + 1);
            link_prev[i]  = '0;
            slot_live[i]  = 1'b0;
        end
        free_head   = arll_pkg::IDX_W'(1);
        live_total  = '0;
        poison_word = '0;
    endtask

    // Apply one request to the list image and return the result it must produce.
    function automatic arll_pkg::t_res list_apply(input arll_pkg::t_req r);
        arll_pkg::t_res             rs;
        logic [arll_pkg::IDX_W-1:0] a;
        logic [arll_pkg::IDX_W-1:0] base;
        logic [arll_pkg::IDX_W-1:0] s;
        logic [arll_pkg::IDX_W-1:0] succ;
        logic [arll_pkg::IDX_W-1:0] p;
        rs = '0;
        a = r.anchor_index;
        rs.slot = a;
        rs.status = arll_pkg::STS_OK;
        case (r.req_type)
            arll_pkg::REQ_INS_AFTER, arll_pkg::REQ_INS_BEFORE: begin
                if (a != 0 && !slot_live[a]) begin
                    rs.status = arll_pkg::STS_BAD;
                end else if (free_head == 0) begin
                    rs.status = arll_pkg::STS_FULL;
                end else begin
                    base = (r.req_type == arll_pkg::REQ_INS_BEFORE) ? link_prev[a] : a;
                    s = free_head;
                    free_head = link_next[s];
                    succ = link_next[base];
                    slot_value[s] = r.item_value;
                    link_prev[s] = base;
                    link_next[s] = succ;
                    link_prev[succ] = s;
                    link_next[base] = s;
                    slot_live[s] = 1'b1;
                    live_total++;
                    rs.slot = s;
                    rs.next_slot = link_next[s];
                    rs.prev_slot = link_prev[s];
                end
            end
            arll_pkg::REQ_REMOVE: begin
                if (a == 0 || !slot_live[a]) begin
                    rs.status = arll_pkg::STS_BAD;
                end else begin
                    rs.value_out = slot_value[a];
                    p = link_prev[a];
                    succ = link_next[a];
                    link_next[p] = succ;
                    link_prev[succ] = p;
                    slot_value[a] = poison_word;
                    slot_live[a] = 1'b0;
                    // freed slot goes on top of the free stack
                    link_next[a] = free_head;
                    link_prev[a] = '0;
                    free_head = a;
                    live_total--;
                    rs.next_slot = link_next[a];
                end
            end
            default: begin
                if (a != 0 && !slot_live[a]) begin
                    rs.status = arll_pkg::STS_BAD;
                end else begin
                    rs.value_out = slot_value[a];
                    rs.next_slot = link_next[a];
                    rs.prev_slot = link_prev[a];
                end
            end
        endcase
        rs.element_count = live_total;
        case (rs.status)
            arll_pkg::STS_OK:   n_ok++;
            arll_pkg::STS_FULL: n_full++;
            default:            n_bad++;
        endcase
        if (int'(live_total) > peak_live) peak_live = int'(live_total);
        return rs;
    endfunction

    // Sender: offer pending items, idle at random unless steady is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) results_due.push_back(list_apply(req_ch.data));
            if (!req_ch.valid || req_ch.ready) begin
                if (pending.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending.pop_front();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result(input arll_pkg::t_res got);
        arll_pkg::t_res want;
        n_taken++;
        if (results_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: st=%0d slot=%0d val=%h nx=%0d pv=%0d cnt=%0d",
                         got.status, got.slot, got.value_out, got.next_slot, got.prev_slot,
                         got.element_count);
            return;
        end
        want = results_due.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.value_out !== want.value_out || got.next_slot !== want.next_slot ||
            got.prev_slot !== want.prev_slot || got.element_count !== want.element_count) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch on result %0d", n_taken);
                $display("  expected st=%0d slot=%0d val=%h nx=%0d pv=%0d cnt=%0d",
                         want.status, want.slot, want.value_out, want.next_slot,
                         want.prev_slot, want.element_count);
                $display("  actual   st=%0d slot=%0d val=%h nx=%0d pv=%0d cnt=%0d",
                         got.status, got.slot, got.value_out, got.next_slot,
                         got.prev_slot, got.element_count);
            end
        end
    endtask

    // Receiver: take results, stall at random unless steady is set, and once hold off for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) check_result(res_ch.data);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!stall_done && n_taken >= STALL_AT) begin
                res_ch.ready <= 1'b0;
                stall_left <= STALL_CYCLES;
                stall_done <= 1'b1;
            end else begin
                res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                     (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_poison(input logic [arll_pkg::CFG_W-1:0] w);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        poison_word = w;
        n_poison++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending.size() != 0 || req_ch.valid || results_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic arll_pkg::t_req make_item(
        input logic [arll_pkg::TYPE_W-1:0] kind,
        input int anchor,
        input logic [arll_pkg::DATA_W-1:0] v);
        arll_pkg::t_req r;
        r.req_type = kind;
        r.anchor_index = arll_pkg::IDX_W'(anchor);
        r.item_value = v;
        return r;
    endfunction

    // Pick a slot that is currently in the list, or a free one when the list is empty.
    function automatic int live_slot();
        int start;
        int idx;
        start = $urandom_range(1, SLOTS - 1);
        for (int j = 0; j < SLOTS - 1; j++) begin
            idx = 1 + (start - 1 + j) % (SLOTS - 1);
            if (slot_live[idx]) return idx;
        end
        return start;
    endfunction

    function automatic arll_pkg::t_req random_item(input int p_ins, input int p_rem);
        arll_pkg::t_req r;
        int             roll;
        roll = $urandom_range(0, 99);
        if (roll < p_ins)
            r.req_type = $urandom_range(0, 1) ? arll_pkg::REQ_INS_BEFORE
                                              : arll_pkg::REQ_INS_AFTER;
        else if (roll < p_ins + p_rem)
            r.req_type = arll_pkg::REQ_REMOVE;
        else
            r.req_type = arll_pkg::REQ_READ;
        roll = $urandom_range(0, 99);
        if (roll < 70)      r.anchor_index = arll_pkg::IDX_W'(live_slot());
        else if (roll < 82) r.anchor_index = '0;
        else                r.anchor_index = arll_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
        case ($urandom_range(0, 9))
            0:       r.item_value = '0;
            1:       r.item_value = '1;
            default: r.item_value = $urandom;
        endcase
        return r;
    endfunction

    task automatic run_random(input int n, input int p_ins, input int p_rem);
        for (int i = 0; i < n; i++) begin
            @(negedge i_clk);
            // keep the queue short so anchors follow the live list closely
            while (pending.size() >= 2) @(negedge i_clk);
            pending.push_back(random_item(p_ins, p_rem));
        end
    endtask

    initial begin
        clear_list();
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_poison('1);

        // directed: bad anchors on an empty list, push front/back, inner inserts,
        // slot reuse off the free stack, head and tail removal
        pending.push_back(make_item(arll_pkg::REQ_READ, 0, '0));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 0, '0));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 5, '0));
        pending.push_back(make_item(arll_pkg::REQ_READ, 7, '0));
        pending.push_back(make_item(arll_pkg::REQ_INS_AFTER, 255, 32'h1234_5678));
        pending.push_back(make_item(arll_pkg::REQ_INS_BEFORE, 9, 32'h8765_4321));
        pending.push_back(make_item(arll_pkg::REQ_INS_AFTER, 0, '0));
        pending.push_back(make_item(arll_pkg::REQ_INS_BEFORE, 0, '1));
        pending.push_back(make_item(arll_pkg::REQ_INS_AFTER, 1, 32'ha5a5_a5a5));
        pending.push_back(make_item(arll_pkg::REQ_INS_BEFORE, 2, 32'h5a5a_5a5a));
        pending.push_back(make_item(arll_pkg::REQ_READ, 0, '0));
        pending.push_back(make_item(arll_pkg::REQ_READ, 3, '0));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 3, '0));
        pending.push_back(make_item(arll_pkg::REQ_READ, 3, '0));
        pending.push_back(make_item(arll_pkg::REQ_INS_AFTER, 4, 32'h0000_0001));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 1, '0));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 2, '0));
        pending.push_back(make_item(arll_pkg::REQ_READ, 4, '0));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 4, '0));
        pending.push_back(make_item(arll_pkg::REQ_REMOVE, 3, '0));
        pending.push_back(make_item(arll_pkg::REQ_READ, 0, '0));
        pending.push_back(make_item(arll_pkg::REQ_INS_BEFORE, 0, '1));
        wait_idle();

        // fill until full and beyond, with idling and the long result hold-off
        write_poison('0);
        run_random(750, 80, 8);
        wait_idle();

        // drain back toward empty without any idling
        write_poison($urandom);
        steady = 1'b1;
        run_random(550, 15, 65);
        wait_idle();
        steady = 1'b0;

        write_poison('1);
        run_random(650, 40, 35);
        wait_idle();
        repeat (20) @(negedge i_clk);

        errors += results_due.size();
        $display("%0d results checked: %0d ok, %0d list full, %0d bad anchor; peak %0d elements",
                 n_taken, n_ok, n_full, n_bad, peak_live);
        $display("poison word written %0d times, including all zeros and all ones; %0d errors",
                 n_poison, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
